### rtl/hht_pkg.sv
package hht_pkg;

	// Result kinds
	localparam logic [2:0] KIND_TOKEN_BYTE   = 3'd0;
	localparam logic [2:0] KIND_TOKEN_END    = 3'd1;
	localparam logic [2:0] KIND_SEPARATOR    = 3'd2;
	localparam logic [2:0] KIND_LINE_END     = 3'd3;
	localparam logic [2:0] KIND_TERMINATE    = 3'd4;
	localparam logic [2:0] KIND_BAD_LINE_END = 3'd5;

	// Byte codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL   = 8'h7F;

	// Result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] char_out;
		logic       last;
	} out_item_t;

	// Outcome of lexing one byte: up to two results plus next state
	typedef struct packed {
		logic [1:0] n;
		out_item_t  e0;
		out_item_t  e1;
		logic       in_token;
		logic       pend;
		logic       pend_cr;
	} lex_t;

	function automatic logic is_sep(input logic [7:0] b);
		logic r;
		unique case (b)
			8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
			8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D: r = 1'b1;
			default: r = (b < CH_SPACE) || (b == CH_DEL);
		endcase
		return r;
	endfunction

	function automatic out_item_t mk(input logic [2:0] kind, input logic [7:0] ch);
		out_item_t o;
		o.kind     = kind;
		o.char_out = ch;
		o.last     = 1'b0;
		return o;
	endfunction

	// Lex one byte with no line end pending
	function automatic lex_t lex_byte(input logic [7:0] b, input logic in_tok);
		lex_t l;
		l.n        = 2'd0;
		l.e0       = mk(KIND_TOKEN_END, 8'h00);
		l.e1       = mk(KIND_TOKEN_END, 8'h00);
		l.in_token = in_tok;
		l.pend     = 1'b0;
		l.pend_cr  = 1'b0;
		if (b == CH_SPACE || b == CH_TAB) begin
			l.n        = {1'b0, in_tok};
			l.in_token = 1'b0;
		end else if (b == CH_CR || b == CH_LF) begin
			l.n        = {1'b0, in_tok};
			l.in_token = 1'b0;
			l.pend     = 1'b1;
			l.pend_cr  = (b == CH_CR);
		end else if (is_sep(b)) begin
			l.in_token = 1'b0;
			if (in_tok) begin
				l.n  = 2'd2;
				l.e1 = mk(KIND_SEPARATOR, b);
			end else begin
				l.n  = 2'd1;
				l.e0 = mk(KIND_SEPARATOR, b);
			end
		end else begin
			l.n        = 2'd1;
			l.e0       = mk(KIND_TOKEN_BYTE, b);
			l.in_token = 1'b1;
		end
		return l;
	endfunction

endpackage

### rtl/http_header_tokenizer_top.sv
// HTTP header lexer: takes one header byte per transaction and returns zero, one or two
// results (token byte, token end, separator, line end, nonconforming line end, terminate),
// with last set on the final result of each byte. A byte is classified and the lexer state
// updated in the cycle it is accepted, and its results enter a four-entry result queue that
// drains one result per cycle while result_ready is high. The input is ready whenever
// the queue has at least two free entries, so bytes are taken every cycle while results
// drain and each yields at most one result; results are registered in the queue.
module http_header_tokenizer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  hht_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_ready,
	output hht_pkg::out_item_t  result
);

	logic                      in_token_q;
	logic                      pend_q;
	logic                      pend_cr_q;
	hht_pkg::out_item_t        queue_q [hht_pkg::QDEPTH];
	logic [hht_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [hht_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [hht_pkg::QCNT_W-1:0] count_q;

	hht_pkg::lex_t             step;
	hht_pkg::lex_t             lx;
	logic                      push;
	logic                      pop;
	logic [hht_pkg::QPTR_W-1:0] wr_ptr_p1;

	assign item_ready   = (count_q <= hht_pkg::QCNT_W'(hht_pkg::QDEPTH - 2));
	assign result_valid = (count_q != '0);
	assign result       = queue_q[rd_ptr_q];
	assign push         = item_valid && item_ready;
	assign pop          = result_valid && result_ready;
	assign wr_ptr_p1    = wr_ptr_q + 1'b1;

	// Classify the incoming byte against the current state
	always_comb begin
		lx   = hht_pkg::lex_byte(item.char_in, in_token_q);
		step = lx;
		if (item.end_of_input) begin
			step.in_token = 1'b0;
			step.pend     = 1'b0;
			step.pend_cr  = 1'b0;
			if (!pend_q && in_token_q) begin
				step.n  = 2'd2;
				step.e0 = hht_pkg::mk(hht_pkg::KIND_TOKEN_END, 8'h00);
				step.e1 = hht_pkg::mk(hht_pkg::KIND_TERMINATE, 8'h00);
			end else begin
				step.n  = 2'd1;
				step.e0 = hht_pkg::mk(hht_pkg::KIND_TERMINATE, 8'h00);
			end
		end else if (pend_q) begin
			if (pend_cr_q && item.char_in == hht_pkg::CH_LF) begin
				step.n        = 2'd1;
				step.e0       = hht_pkg::mk(hht_pkg::KIND_LINE_END, 8'h00);
				step.in_token = 1'b0;
				step.pend     = 1'b0;
				step.pend_cr  = 1'b0;
			end else begin
				// Token is never open here, so the fresh byte adds at most one result
				step.e0 = hht_pkg::mk(hht_pkg::KIND_BAD_LINE_END, 8'h00);
				step.e1 = lx.e0;
				step.n  = (lx.n == 2'd0) ? 2'd1 : 2'd2;
			end
		end
		step.e0.last = (step.n == 2'd1);
		step.e1.last = 1'b1;
	end

	// Advance lexer state and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_token_q <= 1'b0;
			pend_q     <= 1'b0;
			pend_cr_q  <= 1'b0;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
		end else begin
			if (push) begin
				in_token_q <= step.in_token;
				pend_q     <= step.pend;
				pend_cr_q  <= step.pend_cr;
				wr_ptr_q   <= wr_ptr_q + hht_pkg::QPTR_W'(step.n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (push ? hht_pkg::QCNT_W'(step.n) : '0)
				- hht_pkg::QCNT_W'(pop);
		end
	end

	// Write results into the queue
	always_ff @(posedge clk) begin
		if (push && step.n != 2'd0) begin
			queue_q[wr_ptr_q] <= step.e0;
		end
		if (push && step.n == 2'd2) begin
			queue_q[wr_ptr_p1] <= step.e1;
		end
	end

endmodule
